>>> hdl/quad_motor_mixer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quad motor mixer
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUAD_MOTOR_MIXER_MACROS_SVH
`define QUAD_MOTOR_MIXER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QMM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);
`define QMM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QMM_ASSERT_IMP(label, ante, cons, msg)
`define QMM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/qmm_pkg.sv
// ----------------------------------------------------------------------------
// qmm_pkg
// Types, constants and small helper functions shared by the mixer modules.
// ----------------------------------------------------------------------------
package qmm_pkg;

  localparam int QMM_ADDR_W  = 5;
  localparam int QMM_DATA_W  = 64;
  localparam int QMM_LATENCY = 8;

  typedef enum logic [1:0] {
    OP_LEGACY = 2'd0,
    OP_FT     = 2'd1,
    OP_NORM   = 2'd2,
    OP_NONE   = 2'd3
  } qmm_op_t;

  localparam logic [1:0] REG_RP_GAIN     = 2'd0;
  localparam logic [1:0] REG_YAW_GAIN    = 2'd1;
  localparam logic [1:0] REG_FORCE_SCALE = 2'd2;

  typedef struct packed {
    logic [31:0] roll_pitch_gain;
    logic [31:0] yaw_gain;
    logic [47:0] force_scale;
  } qmm_cfg_t;

  // Torque stage output: signed Q.18 force parts plus the direct result
  // of the legacy and normalized modes.
  typedef struct packed {
    logic               valid;
    qmm_op_t            op;
    logic signed [31:0] thrust;
    logic signed [50:0] roll_part;
    logic signed [50:0] pitch_part;
    logic signed [50:0] yaw_part;
    logic [3:0][31:0]   direct;
  } qmm_mid_t;

  function automatic logic [31:0] qmm_sat32(input logic signed [34:0] x);
    if (x > 35'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (x < -35'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  // Clamp a Q2.15 force to [0,1] and scale by 65535: (c << 16) - c, then >> 15.
  function automatic logic [31:0] qmm_norm_scale(input logic signed [16:0] f);
    logic [15:0] c;
    logic [32:0] prod;
    if (f[16]) begin
      c = 16'h0000;
    end else if (f > 17'sd32768) begin
      c = 16'h8000;
    end else begin
      c = f[15:0];
    end
    prod = {1'b0, c, 16'h0000} - {17'h00000, c};
    return {14'h0000, prod[32:15]};
  endfunction

endpackage

>>> hdl/qmm_regs.sv
// ----------------------------------------------------------------------------
// qmm_regs
// APB-style configuration registers: two gains and the force scale.
// ----------------------------------------------------------------------------
module qmm_regs import qmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [QMM_ADDR_W-1:0] paddr,
  input  logic [QMM_DATA_W-1:0] pwdata,
  output logic [QMM_DATA_W-1:0] prdata,
  output logic                  pready,
  output qmm_cfg_t              cfg
);

  qmm_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[QMM_ADDR_W-1:3];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RP_GAIN:     cfg_r.roll_pitch_gain <= pwdata[31:0];
        REG_YAW_GAIN:    cfg_r.yaw_gain        <= pwdata[31:0];
        REG_FORCE_SCALE: cfg_r.force_scale     <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RP_GAIN:     prdata = {32'h0, cfg_r.roll_pitch_gain};
      REG_YAW_GAIN:    prdata = {32'h0, cfg_r.yaw_gain};
      REG_FORCE_SCALE: prdata = {16'h0, cfg_r.force_scale};
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hdl/qmm_torque.sv
// ----------------------------------------------------------------------------
// qmm_torque
// Stages one to four: input register, legacy and normalized results,
// gain products and signed torque parts in Q.18.
// ----------------------------------------------------------------------------
module qmm_torque import qmm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_operation,
  input  logic signed [31:0]  in_thrust_word,
  input  logic signed [31:0]  in_roll_word,
  input  logic signed [31:0]  in_pitch_word,
  input  logic signed [31:0]  in_yaw_word,
  input  logic signed [16:0]  in_motor1_force,
  input  logic signed [16:0]  in_motor2_force,
  input  logic signed [16:0]  in_motor3_force,
  input  logic signed [16:0]  in_motor4_force,
  input  qmm_cfg_t            cfg,
  output qmm_mid_t            mid
);

  // Stage 1
  logic               s1_valid_r;
  qmm_op_t            s1_op_r;
  logic signed [31:0] s1_thrust_r, s1_roll_r, s1_pitch_r, s1_yaw_r;
  logic [3:0][16:0]   s1_force_r;

  // Stage 2
  logic               s2_valid_r;
  qmm_op_t            s2_op_r;
  logic signed [31:0] s2_thrust_r;
  logic [31:0]        s2_rmag_r, s2_pmag_r, s2_ymag_r;
  logic               s2_rneg_r, s2_pneg_r, s2_yneg_r;
  logic [3:0][31:0]   s2_direct_r;

  // Stage 3
  logic               s3_valid_r;
  qmm_op_t            s3_op_r;
  logic signed [31:0] s3_thrust_r;
  logic [63:0]        s3_rprod_r, s3_pprod_r, s3_yprod_r;
  logic               s3_rneg_r, s3_pneg_r, s3_yneg_r;
  logic [3:0][31:0]   s3_direct_r;

  // Stage 4
  logic               s4_valid_r;
  qmm_op_t            s4_op_r;
  logic signed [31:0] s4_thrust_r;
  logic signed [50:0] s4_rpart_r, s4_ppart_r, s4_ypart_r;
  logic [3:0][31:0]   s4_direct_r;

  logic [31:0]        rmag_nxt, pmag_nxt, ymag_nxt;
  logic signed [32:0] radj, padj;
  logic signed [31:0] rhalf, phalf;
  logic signed [34:0] leg_sum [4];
  logic [3:0][31:0]   direct_nxt;
  logic signed [50:0] rpart_nxt, ppart_nxt, ypart_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && (qmm_op_t'(in_operation) != OP_NONE);
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // Magnitudes of the torques and the legacy and normalized results.
  always_comb begin
    rmag_nxt = s1_roll_r[31]  ? (~s1_roll_r  + 32'd1) : s1_roll_r;
    pmag_nxt = s1_pitch_r[31] ? (~s1_pitch_r + 32'd1) : s1_pitch_r;
    ymag_nxt = s1_yaw_r[31]   ? (~s1_yaw_r   + 32'd1) : s1_yaw_r;

    // Halving that truncates toward zero: add one to negatives, then shift.
    radj  = {s1_roll_r[31], s1_roll_r}   + {32'h0, s1_roll_r[31]};
    padj  = {s1_pitch_r[31], s1_pitch_r} + {32'h0, s1_pitch_r[31]};
    rhalf = radj[32:1];
    phalf = padj[32:1];

    leg_sum[0] = 35'(s1_thrust_r) - 35'(rhalf) + 35'(phalf) + 35'(s1_yaw_r);
    leg_sum[1] = 35'(s1_thrust_r) - 35'(rhalf) - 35'(phalf) - 35'(s1_yaw_r);
    leg_sum[2] = 35'(s1_thrust_r) + 35'(rhalf) - 35'(phalf) + 35'(s1_yaw_r);
    leg_sum[3] = 35'(s1_thrust_r) + 35'(rhalf) + 35'(phalf) - 35'(s1_yaw_r);

    for (int i = 0; i < 4; i++) begin
      case (s1_op_r)
        OP_LEGACY: direct_nxt[i] = qmm_sat32(leg_sum[i]);
        OP_NORM:   direct_nxt[i] = qmm_norm_scale($signed(s1_force_r[i]));
        default:   direct_nxt[i] = '0;
      endcase
    end
  end

  // Product to Q.18 truncates the magnitude, so the sign goes on afterwards.
  always_comb begin
    rpart_nxt = s3_rneg_r ? -$signed({1'b0, s3_rprod_r[63:14]})
                          :  $signed({1'b0, s3_rprod_r[63:14]});
    ppart_nxt = s3_pneg_r ? -$signed({1'b0, s3_pprod_r[63:14]})
                          :  $signed({1'b0, s3_pprod_r[63:14]});
    ypart_nxt = s3_yneg_r ? -$signed({1'b0, s3_yprod_r[63:14]})
                          :  $signed({1'b0, s3_yprod_r[63:14]});
  end

  always_ff @(posedge clk) begin
    s1_op_r     <= qmm_op_t'(in_operation);
    s1_thrust_r <= in_thrust_word;
    s1_roll_r   <= in_roll_word;
    s1_pitch_r  <= in_pitch_word;
    s1_yaw_r    <= in_yaw_word;
    s1_force_r  <= {in_motor4_force, in_motor3_force, in_motor2_force, in_motor1_force};

    s2_op_r     <= s1_op_r;
    s2_thrust_r <= s1_thrust_r;
    s2_rmag_r   <= rmag_nxt;
    s2_pmag_r   <= pmag_nxt;
    s2_ymag_r   <= ymag_nxt;
    s2_rneg_r   <= s1_roll_r[31];
    s2_pneg_r   <= s1_pitch_r[31];
    s2_yneg_r   <= s1_yaw_r[31];
    s2_direct_r <= direct_nxt;

    s3_op_r     <= s2_op_r;
    s3_thrust_r <= s2_thrust_r;
    s3_rprod_r  <= s2_rmag_r * cfg.roll_pitch_gain;
    s3_pprod_r  <= s2_pmag_r * cfg.roll_pitch_gain;
    s3_yprod_r  <= s2_ymag_r * cfg.yaw_gain;
    s3_rneg_r   <= s2_rneg_r;
    s3_pneg_r   <= s2_pneg_r;
    s3_yneg_r   <= s2_yneg_r;
    s3_direct_r <= s2_direct_r;

    s4_op_r     <= s3_op_r;
    s4_thrust_r <= s3_thrust_r;
    s4_rpart_r  <= rpart_nxt;
    s4_ppart_r  <= ppart_nxt;
    s4_ypart_r  <= ypart_nxt;
    s4_direct_r <= s3_direct_r;
  end

  always_comb begin
    mid.valid      = s4_valid_r;
    mid.op         = s4_op_r;
    mid.thrust     = s4_thrust_r;
    mid.roll_part  = s4_rpart_r;
    mid.pitch_part = s4_ppart_r;
    mid.yaw_part   = s4_ypart_r;
    mid.direct     = s4_direct_r;
  end

endmodule

>>> hdl/qmm_pwm.sv
// ----------------------------------------------------------------------------
// qmm_pwm
// Stages five to eight: per-motor forces, force-to-PWM scaling as split
// partial products with saturation, and the output register.
// ----------------------------------------------------------------------------
`include "quad_motor_mixer_macros.svh"

module qmm_pwm import qmm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  qmm_mid_t         mid,
  input  qmm_cfg_t         cfg,
  output logic             out_valid,
  output logic [3:0][31:0] out_thrust
);

  // Stage 5: clamped forces
  logic             s5_valid_r;
  qmm_op_t          s5_op_r;
  logic [3:0][31:0] s5_direct_r;
  logic [3:0][51:0] s5_force_r;

  // Stage 6: partial products
  logic             s6_valid_r;
  qmm_op_t          s6_op_r;
  logic [3:0][31:0] s6_direct_r;
  logic [3:0][63:0] s6_p00_r;
  logic [3:0][47:0] s6_p01_r;
  logic [3:0][51:0] s6_p10_r;
  logic [3:0][35:0] s6_p11_r;

  // Stage 7: middle partial sum
  logic             s7_valid_r;
  qmm_op_t          s7_op_r;
  logic [3:0][31:0] s7_direct_r;
  logic [3:0][63:0] s7_p00_r;
  logic [3:0][35:0] s7_p11_r;
  logic [3:0][52:0] s7_mid_r;

  logic             out_valid_r;
  logic [3:0][31:0] out_thrust_r;

  logic signed [52:0] force_sum [4];
  logic [3:0][51:0]   force_nxt;
  logic [3:0][100:0]  total;
  logic [3:0][31:0]   thrust_nxt;

  always_comb begin
    force_sum[0] = 53'(mid.thrust) - 53'(mid.roll_part) - 53'(mid.pitch_part)
                 - 53'(mid.yaw_part);
    force_sum[1] = 53'(mid.thrust) - 53'(mid.roll_part) + 53'(mid.pitch_part)
                 + 53'(mid.yaw_part);
    force_sum[2] = 53'(mid.thrust) + 53'(mid.roll_part) + 53'(mid.pitch_part)
                 - 53'(mid.yaw_part);
    force_sum[3] = 53'(mid.thrust) + 53'(mid.roll_part) - 53'(mid.pitch_part)
                 + 53'(mid.yaw_part);
    for (int i = 0; i < 4; i++) begin
      force_nxt[i] = force_sum[i][52] ? 52'h0 : force_sum[i][51:0];
    end
  end

  // Only product bits 34 and up matter; anything at bit 65 or above saturates.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      total[i] = {1'b0, s7_p11_r[i], 64'h0} + {16'h0, s7_mid_r[i], 32'h0}
               + {37'h0, s7_p00_r[i]};
      if (s7_op_r != OP_FT) begin
        thrust_nxt[i] = s7_direct_r[i];
      end else if (|total[i][100:65]) begin
        thrust_nxt[i] = 32'h7FFF_FFFF;
      end else begin
        thrust_nxt[i] = {1'b0, total[i][64:34]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      s7_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s5_valid_r  <= mid.valid;
      s6_valid_r  <= s5_valid_r;
      s7_valid_r  <= s6_valid_r;
      out_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_op_r     <= mid.op;
    s5_direct_r <= mid.direct;
    s5_force_r  <= force_nxt;

    s6_op_r     <= s5_op_r;
    s6_direct_r <= s5_direct_r;
    for (int i = 0; i < 4; i++) begin
      s6_p00_r[i] <= s5_force_r[i][31:0]  * cfg.force_scale[31:0];
      s6_p01_r[i] <= s5_force_r[i][31:0]  * cfg.force_scale[47:32];
      s6_p10_r[i] <= s5_force_r[i][51:32] * cfg.force_scale[31:0];
      s6_p11_r[i] <= s5_force_r[i][51:32] * cfg.force_scale[47:32];
    end

    s7_op_r     <= s6_op_r;
    s7_direct_r <= s6_direct_r;
    s7_p00_r    <= s6_p00_r;
    s7_p11_r    <= s6_p11_r;
    for (int i = 0; i < 4; i++) begin
      s7_mid_r[i] <= {5'h0, s6_p01_r[i]} + {1'b0, s6_p10_r[i]};
    end

    out_thrust_r <= thrust_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_thrust = out_thrust_r;

  `QMM_ASSERT_NXT(a_ft_nonneg, s7_valid_r && s7_op_r == OP_FT,
    !out_thrust_r[0][31] && !out_thrust_r[1][31] && !out_thrust_r[2][31] &&
    !out_thrust_r[3][31], "force-torque beat gave a negative thrust")
  `QMM_ASSERT_NXT(a_norm_range, s7_valid_r && s7_op_r == OP_NORM,
    out_thrust_r[0] <= 32'd65535 && out_thrust_r[1] <= 32'd65535 &&
    out_thrust_r[2] <= 32'd65535 && out_thrust_r[3] <= 32'd65535,
    "normalized force beat exceeded 65535")

endmodule

>>> hdl/quad_motor_mixer.sv
// ----------------------------------------------------------------------------
// quad_motor_mixer
// X quadrotor motor mixer: legacy, force-torque and normalized force modes.
// ----------------------------------------------------------------------------
// A result strobes on out_valid when its command leaves the last pipeline stage.
// Throughput: one command per cycle; busy is never high, since the 8-stage
// pipeline has no feedback and the receiver cannot stall it.
// Operation 3 is dropped at the input stage and gives no result beat.
// Reset clears all pipeline valid bits and the configuration registers to 0.
`include "quad_motor_mixer_macros.svh"

module quad_motor_mixer import qmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic signed [31:0]    in_thrust_word,
  input  logic signed [31:0]    in_roll_word,
  input  logic signed [31:0]    in_pitch_word,
  input  logic signed [31:0]    in_yaw_word,
  input  logic signed [16:0]    in_motor1_force,
  input  logic signed [16:0]    in_motor2_force,
  input  logic signed [16:0]    in_motor3_force,
  input  logic signed [16:0]    in_motor4_force,
  output logic                  out_valid,
  output logic signed [31:0]    out_motor1_thrust,
  output logic signed [31:0]    out_motor2_thrust,
  output logic signed [31:0]    out_motor3_thrust,
  output logic signed [31:0]    out_motor4_thrust,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [QMM_ADDR_W-1:0] paddr,
  input  logic [QMM_DATA_W-1:0] pwdata,
  output logic [QMM_DATA_W-1:0] prdata,
  output logic                  pready
);

  qmm_cfg_t         cfg;
  qmm_mid_t         mid;
  logic [3:0][31:0] thrust;

  assign busy = 1'b0;

  qmm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qmm_torque u_torque (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_operation    (in_operation),
    .in_thrust_word  (in_thrust_word),
    .in_roll_word    (in_roll_word),
    .in_pitch_word   (in_pitch_word),
    .in_yaw_word     (in_yaw_word),
    .in_motor1_force (in_motor1_force),
    .in_motor2_force (in_motor2_force),
    .in_motor3_force (in_motor3_force),
    .in_motor4_force (in_motor4_force),
    .cfg             (cfg),
    .mid             (mid)
  );

  qmm_pwm u_pwm (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid        (mid),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_thrust (thrust)
  );

  assign out_motor1_thrust = thrust[0];
  assign out_motor2_thrust = thrust[1];
  assign out_motor3_thrust = thrust[2];
  assign out_motor4_thrust = thrust[3];

  `QMM_ASSERT_IMP(a_cmd_gives_beat,
    start && !busy && in_operation != OP_NONE, ##QMM_LATENCY out_valid,
    "accepted command produced no result beat")
  `QMM_ASSERT_IMP(a_beat_has_cmd, out_valid,
    $past(start && !busy && in_operation != OP_NONE, QMM_LATENCY),
    "result beat without a matching command")

endmodule
